// ----- hw/rtl/chs_pkg.sv -----
// Shared types, constants and the arctangent table of the compass heading unit.
package chs_pkg;

   // Sample and register widths settled by the item fields
   localparam int SAMPLE_BITS = 16;
   localparam int DECL_BITS   = 15;

   // Build defaults of the top-level parameters
   localparam int DEFAULT_SECTOR_DEGREES    = 30;
   localparam int DEFAULT_CORDIC_ITERATIONS = 16;

   // Vector widths: difference of two samples, then the prescale into the wide datapath
   localparam int PREP_BITS = SAMPLE_BITS + 1;
   localparam int PRESCALE  = 58 - SAMPLE_BITS;
   localparam int VEC_BITS  = 62;

   // Angle unit is 1/4096 arcminute
   localparam int ANGLE_BITS    = 28;
   localparam int WRAP_BITS     = 29;
   localparam int CIRCLE_BITS   = 27;
   localparam int UNITS_PER_DEG = 245760;
   localparam int FULL_CIRCLE   = 88473600;
   localparam int DECL_SHIFT    = 12;

   // Whole degrees: drop 2^14, then divide by 15 through a reciprocal
   localparam int DEG_SHIFT      = 14;
   localparam int DEG_MULT       = 17477;
   localparam int DEG_MULT_BITS  = 15;
   localparam int DEG_MULT_SHIFT = 18;
   localparam int HEADING_BITS   = 9;
   localparam int SECTOR_BITS    = 4;

   localparam int TABLE_LEN = 24;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_X    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_Y    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECLINATION = 2'd2;

   localparam logic signed [DECL_BITS-1:0] DECL_RESET = 15'sd308;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_sample;
      logic signed [SAMPLE_BITS-1:0] y_sample;
   } req_type;

   typedef struct packed {
      logic [HEADING_BITS-1:0] heading_deg;
      logic [SECTOR_BITS-1:0]  sector_index;
   } rsp_type;

   // What one cell hands to the next
   typedef struct packed {
      logic                         valid;
      logic signed [VEC_BITS-1:0]   x;
      logic signed [VEC_BITS-1:0]   y;
      logic signed [ANGLE_BITS-1:0] z;
   } cordic_type;

   // atan(2^-i) in angle units, rounded to nearest
   function automatic logic [ANGLE_BITS-1:0] atan_units(input int idx);
      logic [ANGLE_BITS-1:0] val;
      case (idx)
         0:       val = 28'd11059200;
         1:       val = 28'd6528627;
         2:       val = 28'd3449547;
         3:       val = 28'd1751044;
         4:       val = 28'd878920;
         5:       val = 28'd439888;
         6:       val = 28'd219998;
         7:       val = 28'd110006;
         8:       val = 28'd55004;
         9:       val = 28'd27502;
         10:      val = 28'd13751;
         11:      val = 28'd6875;
         12:      val = 28'd3438;
         13:      val = 28'd1719;
         14:      val = 28'd859;
         15:      val = 28'd430;
         16:      val = 28'd215;
         17:      val = 28'd107;
         18:      val = 28'd54;
         19:      val = 28'd27;
         20:      val = 28'd13;
         21:      val = 28'd7;
         22:      val = 28'd3;
         23:      val = 28'd2;
         default: val = 28'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- hw/rtl/chs_prep.sv -----
// Front stage: hard-iron offset removal and quadrant pre-rotation into the right half plane.
module chs_prep import chs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  req_type                       item,
   input  logic signed [SAMPLE_BITS-1:0] offset_x,
   input  logic signed [SAMPLE_BITS-1:0] offset_y,
   output cordic_type                    prep_out
);

   localparam logic signed [ANGLE_BITS-1:0] DEG90  = ANGLE_BITS'(90 * UNITS_PER_DEG);
   localparam logic signed [ANGLE_BITS-1:0] DEG180 = ANGLE_BITS'(180 * UNITS_PER_DEG);
   localparam int EXT_BITS = VEC_BITS - PREP_BITS - PRESCALE;

   logic signed [PREP_BITS-1:0]  dx, dy, ax, ay, bx, by;
   logic signed [ANGLE_BITS-1:0] za, zb;
   logic                         valid_ff;
   logic signed [VEC_BITS-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_BITS-1:0] z_ff;

   always_comb begin
      dx = PREP_BITS'(item.x_sample) - PREP_BITS'(offset_x);
      dy = PREP_BITS'(item.y_sample) - PREP_BITS'(offset_y);
      // left half plane: negate and start from half a turn
      if (dx < 0) begin
         ax = -dx;
         ay = -dy;
         za = DEG180;
      end else begin
         ax = dx;
         ay = dy;
         za = '0;
      end
      if (ay > 0) begin
         bx = ay;
         by = -ax;
         zb = za + DEG90;
      end else if (ay < 0) begin
         bx = -ay;
         by = ax;
         zb = za - DEG90;
      end else begin
         bx = ax;
         by = ay;
         zb = za;
      end
      x_in = {{EXT_BITS{bx[PREP_BITS-1]}}, bx, {PRESCALE{1'b0}}};
      y_in = {{EXT_BITS{by[PREP_BITS-1]}}, by, {PRESCALE{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= zb;
   end

   assign prep_out = '{valid: valid_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

// ----- hw/rtl/chs_cordic_cell.sv -----
// One vectoring step of the CORDIC chain, registered.
module chs_cordic_cell import chs_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  cordic_type cell_in,
   output cordic_type cell_out
);

   localparam logic signed [ANGLE_BITS-1:0] ATAN_STEP = atan_units(STAGE);

   logic signed [VEC_BITS-1:0]   xs, ys;
   logic signed [VEC_BITS-1:0]   x_in, y_in, x_ff, y_ff;
   logic signed [ANGLE_BITS-1:0] z_in, z_ff;
   logic                         valid_ff;

   always_comb begin
      xs = cell_in.x >>> STAGE;
      ys = cell_in.y >>> STAGE;
      // once y is exactly zero the angle is settled: hold
      if (cell_in.y > 0) begin
         x_in = cell_in.x + ys;
         y_in = cell_in.y - xs;
         z_in = cell_in.z + ATAN_STEP;
      end else if (cell_in.y < 0) begin
         x_in = cell_in.x - ys;
         y_in = cell_in.y + xs;
         z_in = cell_in.z - ATAN_STEP;
      end else begin
         x_in = cell_in.x;
         y_in = cell_in.y;
         z_in = cell_in.z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign cell_out = '{valid: valid_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

// ----- hw/rtl/chs_finish.sv -----
// Back end: declination, wrap to one turn, whole degrees and ring sector.
module chs_finish import chs_pkg::*; #(
   parameter int SECTOR_DEGREES = DEFAULT_SECTOR_DEGREES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cordic_type                  fin_in,
   input  logic signed [DECL_BITS-1:0] declination,
   output logic                        rsp_valid,
   output rsp_type                     rsp_data
);

   localparam logic signed [WRAP_BITS-1:0] CIRCLE = WRAP_BITS'(FULL_CIRCLE);
   localparam int SEC_SHIFT     = 18;
   localparam int SEC_MULT      = ((1 << SEC_SHIFT) + SECTOR_DEGREES - 1) / SECTOR_DEGREES;
   localparam int SEC_MULT_BITS = SEC_SHIFT + 1;
   localparam int SEC_PROD_BITS = HEADING_BITS + SEC_MULT_BITS;
   localparam int Q_BITS        = CIRCLE_BITS - DEG_SHIFT;
   localparam int DEG_PROD_BITS = Q_BITS + DEG_MULT_BITS;

   logic [3:0]                    valid_ff;
   logic signed [DECL_BITS+DECL_SHIFT-1:0] decl_scaled;
   logic signed [WRAP_BITS-1:0]   t_in, t_ff, w1_in, w1_ff, w2_full;
   logic [CIRCLE_BITS-1:0]        w2_ff;
   logic [DEG_PROD_BITS-1:0]      deg_prod;
   logic [HEADING_BITS-1:0]       head_ff;
   logic [SEC_PROD_BITS-1:0]      sec_prod;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff, rsp_in;

   always_comb begin
      decl_scaled = {declination, {DECL_SHIFT{1'b0}}};
      t_in = WRAP_BITS'(fin_in.z) + WRAP_BITS'(decl_scaled);
      // first wrap step brings the angle within one turn either way
      if (t_ff < 0) begin
         w1_in = t_ff + CIRCLE;
      end else if (t_ff >= CIRCLE) begin
         w1_in = t_ff - CIRCLE;
      end else begin
         w1_in = t_ff;
      end
      w2_full = (w1_ff < 0) ? (w1_ff + CIRCLE) : w1_ff;
      deg_prod = DEG_PROD_BITS'(w2_ff[CIRCLE_BITS-1:DEG_SHIFT])
               * DEG_PROD_BITS'(DEG_MULT);
      sec_prod = SEC_PROD_BITS'(head_ff) * SEC_PROD_BITS'(SEC_MULT);
      rsp_in.heading_deg  = head_ff;
      rsp_in.sector_index = sec_prod[SEC_SHIFT +: SECTOR_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[2:0], fin_in.valid};
         rsp_valid_ff <= valid_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      w1_ff   <= w1_in;
      w2_ff   <= w2_full[CIRCLE_BITS-1:0];
      head_ff <= deg_prod[DEG_MULT_SHIFT +: HEADING_BITS];
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/compass_heading_sector_unit.sv -----
// Top level of the compass heading unit: register file, CORDIC cell chain and result stage.
//
// Takes one magnetometer item (x, y) per clock cycle, without gaps: busy stays low, so start
// may be held high for as long as the source has items. Each item comes out as one result
// on rsp_data, marked by a single-cycle rsp_valid strobe; results leave in the order
// the items arrived and must be taken as they appear, since the receiver cannot hold them
// off. Each item passes, in order, the offset removal and quadrant folding register, one
// cell per CORDIC iteration, then registers for declination, the first and second wrap
// step and the degree conversion, and last the sector and output register. The hard-iron
// offsets and declination sit in registers written through csr_we/csr_index/csr_wdata;
// write them only while no item is in flight.
// Headings are floored whole degrees in 0..359; the sector is heading / SECTOR_DEGREES,
// kept to four bits.
module compass_heading_sector_unit import chs_pkg::*; #(
   parameter int SECTOR_DEGREES    = DEFAULT_SECTOR_DEGREES,
   parameter int CORDIC_ITERATIONS = DEFAULT_CORDIC_ITERATIONS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]    csr_wdata
);

   localparam int LATENCY = CORDIC_ITERATIONS + 6;

   logic signed [SAMPLE_BITS-1:0] offset_x_ff, offset_y_ff;
   logic signed [DECL_BITS-1:0]   decl_ff;
   cordic_type                    chain [CORDIC_ITERATIONS+1];

   // Fully pipelined: never refuse an item
   assign busy = 1'b0;

   // Configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decl_ff     <= DECL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_X:    offset_x_ff <= csr_wdata;
            CSR_OFFSET_Y:    offset_y_ff <= csr_wdata;
            CSR_DECLINATION: decl_ff     <= csr_wdata[DECL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Remove offsets and fold the vector into the right half plane
   chs_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .item_valid (start && !busy),
      .item       (req_data),
      .offset_x   (offset_x_ff),
      .offset_y   (offset_y_ff),
      .prep_out   (chain[0])
   );

   // One cell per iteration, each shifting by its own stage number
   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
      chs_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // Add declination, wrap, convert to degrees and sector
   chs_finish #(
      .SECTOR_DEGREES (SECTOR_DEGREES)
   ) u_finish (
      .clock       (clock),
      .reset       (reset),
      .fin_in      (chain[CORDIC_ITERATIONS]),
      .declination (decl_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

`ifndef ASSERT_OFF
   // Every accepted item yields its result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after accepted item");

   // No result without an item accepted the latency before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching item");

   // Wrapped heading stays within one turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.heading_deg < 9'd360))
      else $error("heading out of range");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the compass heading unit: directed headings, then random bursts.
module tb_top;
   import chs_pkg::*;

   // Build of the block under test
   localparam int SECTOR_DEG  = 30;
   localparam int CORDIC_ITER = 16;
   localparam int LATENCY     = CORDIC_ITER + 6;

   // Angle arithmetic of the predictor: 1/4096 arcminute per unit
   localparam longint DEG_UNITS    = 64'd245760;
   localparam longint CIRCLE_UNITS = 64'd88473600;
   localparam int     PRESHIFT     = 58 - SAMPLE_BITS;
   localparam longint ATAN_STEP [0:23] = '{
      11059200, 6528627, 3449547, 1751044, 878920, 439888, 219998, 110006,
      55004, 27502, 13751, 6875, 3438, 1719, 859, 430,
      215, 107, 54, 27, 13, 7, 3, 2
   };

   // Register index with no register behind it: a write there must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 180;
   localparam int CYCLE_LIMIT   = 200000;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_OFFSET_X;
   logic [SAMPLE_BITS-1:0]    csr_wdata = '0;

   // Register contents as the predictor sees them, sign-extended
   longint mag_offset_x    = 0;
   longint mag_offset_y    = 0;
   longint declination_min = longint'(DECL_RESET);

   // Headings still owed by the block, oldest first
   rsp_type expected_headings[$];

   int fail_count  = 0;
   int cycle_count = 0;

   compass_heading_sector_unit #(
      .SECTOR_DEGREES   (SECTOR_DEG),
      .CORDIC_ITERATIONS(CORDIC_ITER)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest correct run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Heading and sector for one sample under the current register contents.
   // Remove the offsets, fold into the right half plane, then run the vectoring
   // steps; a step does nothing once y has reached exactly zero.
   function automatic rsp_type predict_heading(req_type item);
      longint  dx, dy, vx, vy, angle, swap, sx, sy, wrapped, deg;
      int      i;
      rsp_type res;
      dx = longint'(item.x_sample) - mag_offset_x;
      dy = longint'(item.y_sample) - mag_offset_y;
      vx = dx * (longint'(1) << PRESHIFT);
      vy = dy * (longint'(1) << PRESHIFT);
      angle = 0;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         angle = 180 * DEG_UNITS;
      end
      if (vy > 0) begin
         swap  = vx;
         vx    = vy;
         vy    = -swap;
         angle = angle + 90 * DEG_UNITS;
      end else if (vy < 0) begin
         swap  = vx;
         vx    = -vy;
         vy    = swap;
         angle = angle - 90 * DEG_UNITS;
      end
      for (i = 0; i < CORDIC_ITER && i < 24; i++) begin
         // arithmetic shift floors, as the hardware does
         sx = vx >>> i;
         sy = vy >>> i;
         if (vy > 0) begin
            vx    = vx + sy;
            vy    = vy - sx;
            angle = angle + ATAN_STEP[i];
         end else if (vy < 0) begin
            vx    = vx - sy;
            vy    = vy + sx;
            angle = angle - ATAN_STEP[i];
         end
      end
      // Add declination, then wrap into one turn; 360 degrees lands on 0
      wrapped = (angle + declination_min * 4096) % CIRCLE_UNITS;
      if (wrapped < 0) wrapped = wrapped + CIRCLE_UNITS;
      deg = wrapped / DEG_UNITS;
      res.heading_deg  = deg[HEADING_BITS-1:0];
      res.sector_index = SECTOR_BITS'(deg / SECTOR_DEG);
      return res;
   endfunction

   // Offer one sample; hold it until busy is low at an edge, then log the heading it owes.
   // Start is left high so the next item of a burst follows without a gap.
   task automatic send_item(input logic signed [SAMPLE_BITS-1:0] x_val,
                            input logic signed [SAMPLE_BITS-1:0] y_val);
      req_type item;
      item.x_sample = x_val;
      item.y_sample = y_val;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      expected_headings.push_back(predict_heading(item));
   endtask

   // Drop start and let the sender rest for a number of cycles
   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait until every owed heading has come back
   task automatic wait_for_results;
      start <= 1'b0;
      while (expected_headings.size() != 0) @(posedge clock);
   endtask

   // One register write; only called with nothing in flight.
   // Track the write in the predictor: offsets keep 16 bits, declination 15.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [SAMPLE_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_OFFSET_X:    mag_offset_x    = longint'($signed(data));
         CSR_OFFSET_Y:    mag_offset_y    = longint'($signed(data));
         CSR_DECLINATION: declination_min = longint'($signed(data[DECL_BITS-1:0]));
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_registers(input logic [SAMPLE_BITS-1:0] off_x,
                                      input logic [SAMPLE_BITS-1:0] off_y,
                                      input logic [SAMPLE_BITS-1:0] decl);
      write_register(CSR_OFFSET_X, off_x);
      write_register(CSR_OFFSET_Y, off_y);
      write_register(CSR_DECLINATION, decl);
   endtask

   // Every result is taken at the edge that ends its strobe cycle
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_headings.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result: heading %0d sector %0d",
                        rsp_data.heading_deg, rsp_data.sector_index);
            fail_count++;
         end else begin
            want = expected_headings.pop_front();
            if (rsp_data.heading_deg !== want.heading_deg ||
                rsp_data.sector_index !== want.sector_index) begin
               if (fail_count < 10)
                  $display("mismatch: heading exp %0d got %0d, sector exp %0d got %0d",
                           want.heading_deg, rsp_data.heading_deg,
                           want.sector_index, rsp_data.sector_index);
               fail_count++;
            end
         end
      end
   end

   // Reset contents: axes, diagonals, zero vector and the sample extremes
   task automatic test_reset_defaults;
      send_item(16'sd0, 16'sd0);
      send_item(16'sd1, 16'sd0);
      send_item(16'sd0, 16'sd1);
      send_item(-16'sd1, 16'sd0);
      send_item(16'sd0, -16'sd1);
      send_item(16'sd5, 16'sd5);
      send_item(-16'sd32768, -16'sd32768);
      send_item(16'sd32767, -16'sd32768);
      wait_for_results;
   endtask

   // Offsets at opposite extremes so the differences reach their widest, and
   // the declination one arcminute short of a half turn either way
   task automatic test_register_extremes;
      write_all_registers(16'h8000, 16'h7FFF, 16'(10799));
      send_item(16'sd32767, -16'sd32768);
      send_item(-16'sd32768, 16'sd32767);
      wait_for_results;
      write_all_registers(16'h7FFF, 16'h8000, 16'(-10799));
      send_item(-16'sd32768, 16'sd32767);
      send_item(16'sd32767, -16'sd32768);
      wait_for_results;
   endtask

   // Declination beyond a half turn, an ignored top bit, the unused index, and
   // the wrap just below a full turn
   task automatic test_declination_wrap;
      write_all_registers(16'h0000, 16'h0000, 16'h8000 | 16'(16383));
      write_register(CSR_UNUSED, 16'h5A5A);
      send_item(16'sd0, 16'sd0);
      send_item(-16'sd1000, 16'sd1);
      send_item(-16'sd1000, -16'sd1);
      wait_for_results;
      write_register(CSR_DECLINATION, 16'h4000);
      send_item(16'sd1000, -16'sd1);
      send_item(16'sd0, 16'sd0);
      wait_for_results;
      write_register(CSR_DECLINATION, 16'h0000);
      send_item(16'sd1000, -16'sd1);
      send_item(16'sd0, 16'sd0);
      send_item(16'sd1, 16'sd1);
      wait_for_results;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] random_offset;
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'($urandom);
         2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 4000) - 2000);
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_declination;
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return $urandom_range(0, 1) ? 16'(10799) : 16'(-10799);
         2:       return 16'($urandom);
         default: return 16'($urandom_range(0, 21598) - 10799);
      endcase
   endfunction

   // Pick a sample: mostly anywhere, some close to the offsets, some exactly on
   // them, some on an axis or diagonal about them, some at the field extremes
   task automatic send_random_item;
      logic signed [SAMPLE_BITS-1:0] x_val, y_val;
      int span;
      case ($urandom_range(0, 9))
         6: begin
            x_val = 16'(mag_offset_x + $urandom_range(0, 64) - 32);
            y_val = 16'(mag_offset_y + $urandom_range(0, 64) - 32);
         end
         7: begin
            x_val = 16'(mag_offset_x);
            y_val = 16'(mag_offset_y);
         end
         8: begin
            span  = $urandom_range(1, 3000);
            x_val = 16'(mag_offset_x + span * ($urandom_range(0, 2) - 1));
            y_val = 16'(mag_offset_y + span * ($urandom_range(0, 2) - 1));
         end
         9: begin
            case ($urandom_range(0, 3))
               0: x_val = 16'h7FFF;
               1: x_val = 16'h8000;
               2: x_val = 16'h0000;
               default: x_val = 16'hFFFF;
            endcase
            case ($urandom_range(0, 3))
               0: y_val = 16'h7FFF;
               1: y_val = 16'h8000;
               2: y_val = 16'h0000;
               default: y_val = 16'hFFFF;
            endcase
         end
         default: begin
            x_val = 16'($urandom);
            y_val = 16'($urandom);
         end
      endcase
      send_item(x_val, y_val);
   endtask

   // Random register settings per phase; items go out in bursts with random gaps,
   // a quarter of the bursts run straight into the next one
   task automatic test_random_headings;
      int phase, sent, burst, k;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_all_registers(random_offset(), random_offset(), random_declination());
         if ($urandom_range(0, 2) == 0) write_register(CSR_UNUSED, 16'($urandom));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
               send_random_item();
               sent++;
            end
            // hold off once mid-phase until the pipe has emptied
            if (phase == 2 && sent >= PHASE_ITEMS / 2 && sent - k < PHASE_ITEMS / 2)
               wait_for_results;
            else if ($urandom_range(0, 3) != 0)
               pause_sender($urandom_range(1, 2 * LATENCY));
         end
         wait_for_results;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_declination_wrap();
      test_random_headings();

      // Let any stray result surface before judging
      wait_for_results;
      repeat (LATENCY + 4) @(posedge clock);
      fail_count += expected_headings.size();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
